// ----- rtl/vector_field_trilinear_sampler_core_assert.svh -----
// Assertion macros for the sampler core.
`ifndef VECTOR_FIELD_TRILINEAR_SAMPLER_CORE_ASSERT_SVH
`define VECTOR_FIELD_TRILINEAR_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define VFTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define VFTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vfts_pkg.sv -----
package vfts_pkg;

  localparam int MAX_SAMPLES_X_DEF = 64;
  localparam int MAX_SAMPLES_Y_DEF = 64;
  localparam int MAX_FRAMES_DEF    = 4;

  localparam int VAL_W   = 32;
  localparam int POS_W   = 25;  // query position plus one bit for the half-cell offset
  localparam int WGT_W   = 26;  // blend weight, Q8, may exceed one
  localparam int IDX_W   = 11;  // cell index before narrowing
  localparam int ACC_W   = 60;  // product of difference and weight
  localparam int WLO_W   = 13;  // low partial product slice of the weight
  localparam int HALF_STEP = 128;
  localparam int ROUND_HALF = 128;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_INTERP = 2'd1;
  localparam logic [1:0] CMD_DERIV  = 2'd2;

  localparam logic [1:0] CFG_SAMPLES_X  = 2'd0;
  localparam logic [1:0] CFG_SAMPLES_Y  = 2'd1;
  localparam logic [1:0] CFG_NUM_FRAMES = 2'd2;

  localparam logic [6:0] SAMPLES_X_RST  = 7'd64;
  localparam logic [6:0] SAMPLES_Y_RST  = 7'd64;
  localparam logic [2:0] NUM_FRAMES_RST = 3'd4;

  typedef struct packed {
    logic                     start;
    logic signed [VAL_W-1:0]  a;
    logic signed [VAL_W-1:0]  b;
    logic signed [WGT_W-1:0]  w;
  } blend_req_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/vector_field_trilinear_sampler_core.sv -----
// Trilinear sampler for a time-varying 2D vector field held in one on-chip RAM (one
// 64-bit u/v word per grid sample and frame). Command 0 stores a vector; command 1
// returns the interpolated vector; command 2 also returns six central differences
// over half a cell or frame and the vorticity, saturated. All interpolation runs
// through one shared blend unit (two partial-product multiply steps, round, saturate)
// under a small sequencer; the single RAM read port supplies the corners one at a
// time. One sample point takes setup, four read/capture pairs and six blends when the
// time fraction is zero; when two frames are blended each corner adds a second read
// and two time blends. An interpolate item takes one point and a derivative item
// seven; every item also waits while the previous result is still held in the output
// register. The block takes no new item while one is at work; a finished result waits
// in the output register while the next item is already taken. The store has no reset:
// reading a sample never written gives undefined output. The configuration port is
// always ready.
`include "vector_field_trilinear_sampler_core_assert.svh"

module vector_field_trilinear_sampler_core import vfts_pkg::*; #(
  parameter int MAX_SAMPLES_X = MAX_SAMPLES_X_DEF,
  parameter int MAX_SAMPLES_Y = MAX_SAMPLES_Y_DEF,
  parameter int MAX_FRAMES    = MAX_FRAMES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_command,
  input  logic signed [23:0]      in_pos_x,
  input  logic signed [23:0]      in_pos_y,
  input  logic signed [15:0]      in_pos_t,
  input  logic [5:0]              in_write_col,
  input  logic [5:0]              in_write_row,
  input  logic [1:0]              in_write_frame,
  input  logic signed [31:0]      in_write_u,
  input  logic signed [31:0]      in_write_v,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [31:0]      out_value_u,
  output logic signed [31:0]      out_value_v,
  output logic signed [31:0]      out_du_dx,
  output logic signed [31:0]      out_du_dy,
  output logic signed [31:0]      out_du_dt,
  output logic signed [31:0]      out_dv_dx,
  output logic signed [31:0]      out_dv_dy,
  output logic signed [31:0]      out_dv_dt,
  output logic signed [31:0]      out_vorticity,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [6:0]              cfg_data
);

  localparam int XW    = $clog2(MAX_SAMPLES_X);
  localparam int YW    = $clog2(MAX_SAMPLES_Y);
  localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int DEPTH = MAX_FRAMES * MAX_SAMPLES_Y * MAX_SAMPLES_X;
  localparam int AW    = $clog2(DEPTH);
  localparam int MEM_W = 2 * VAL_W;
  localparam logic signed [POS_W-1:0] HALF = POS_W'(HALF_STEP);

  // sample points of a derivative item
  localparam logic [2:0] SMP_CENTER = 3'd0;
  localparam logic [2:0] SMP_XP     = 3'd1;
  localparam logic [2:0] SMP_XM     = 3'd2;
  localparam logic [2:0] SMP_YP     = 3'd3;
  localparam logic [2:0] SMP_YM     = 3'd4;
  localparam logic [2:0] SMP_TP     = 3'd5;
  localparam logic [2:0] SMP_TM     = 3'd6;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SETUP = 9'b000000010,
    S_RD0   = 9'b000000100,
    S_CAP0  = 9'b000001000,
    S_RD1   = 9'b000010000,
    S_BLT   = 9'b000100000,
    S_BLY   = 9'b001000000,
    S_BLX   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r;

  // config registers
  logic [6:0] sx_r, sy_r;
  logic [2:0] nf_r;

  // item registers
  logic [1:0]              cmd_r;
  logic signed [23:0]      x_r, y_r;
  logic signed [15:0]      t_r;

  // sequencer
  logic [1:0] k_r;   // corner
  logic [1:0] bi_r;  // blend op within a step
  logic [2:0] s_r;   // sample point
  logic       bl_wait_r;

  // cell of current point
  logic [XW-1:0] px_r, px1_r;
  logic [YW-1:0] py_r, py1_r;
  logic [FW-1:0] pt_r, pt1_r;
  logic signed [WGT_W-1:0] wx_r, wy_r, wt_r;
  logic                    wt_nz_r;

  logic signed [VAL_W-1:0] cu_r [4];
  logic signed [VAL_W-1:0] cv_r [4];
  logic signed [VAL_W-1:0] su_r [7];
  logic signed [VAL_W-1:0] sv_r [7];

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] o_r [9];

  // ---------------------------------------------------------------------------
  // helpers
  function automatic logic [IDX_W-1:0] top_of(input logic [6:0] r, input int maxv);
    if (r == 7'd0) begin
      return '0;
    end else if (int'(r) > maxv) begin
      return IDX_W'(maxv - 1);
    end else begin
      return IDX_W'(r - 7'd1);
    end
  endfunction

  // truncate toward zero, clamp to 0..top
  function automatic logic [IDX_W-1:0] cell_of(input logic signed [POS_W-1:0] pos,
                                               input logic [IDX_W-1:0] top);
    logic [POS_W-9:0] q;
    q = pos[POS_W-1:8];
    if (pos < 0) begin
      return '0;
    end else if (q > {{(POS_W-8-IDX_W){1'b0}}, top}) begin
      return top;
    end else begin
      return q[IDX_W-1:0];
    end
  endfunction

  function automatic logic signed [WGT_W-1:0] wgt_of(input logic signed [POS_W-1:0] pos,
                                                     input logic [IDX_W-1:0] c);
    return {pos[POS_W-1], pos} - $signed({{(WGT_W-IDX_W-8){1'b0}}, c, 8'd0});
  endfunction

  function automatic logic [AW-1:0] addr_of(input int f, input int r, input int c);
    return AW'((f * MAX_SAMPLES_Y + r) * MAX_SAMPLES_X + c);
  endfunction

  // ---------------------------------------------------------------------------
  // handshakes
  logic in_acc;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // memory
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_rdata;
  logic signed [VAL_W-1:0] rd_u, rd_v;
  logic [XW-1:0]    rd_col;
  logic [YW-1:0]    rd_row;
  logic [FW-1:0]    rd_frm;

  assign ram_we = in_acc && (in_command == CMD_WRITE) && (int'(in_write_col) < MAX_SAMPLES_X)
                  && (int'(in_write_row) < MAX_SAMPLES_Y) && (int'(in_write_frame) < MAX_FRAMES);
  assign ram_waddr = addr_of(int'(in_write_frame), int'(in_write_row), int'(in_write_col));
  assign ram_re    = (state_r == S_RD0) || (state_r == S_RD1);
  assign rd_col    = k_r[1] ? px1_r : px_r;
  assign rd_row    = k_r[0] ? py1_r : py_r;
  assign rd_frm    = (state_r == S_RD1) ? pt1_r : pt_r;
  assign ram_raddr = addr_of(int'(rd_frm), int'(rd_row), int'(rd_col));
  assign rd_u      = ram_rdata[MEM_W-1:VAL_W];
  assign rd_v      = ram_rdata[VAL_W-1:0];

  vfts_ram #(.WIDTH(MEM_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_write_u, in_write_v}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // current sample point and its cell
  logic signed [POS_W-1:0] cur_x, cur_y, cur_t;
  logic [IDX_W-1:0] top_x, top_y, top_t, cx, cy, ct;

  always_comb begin
    cur_x = {x_r[23], x_r};
    cur_y = {y_r[23], y_r};
    cur_t = {{(POS_W-16){t_r[15]}}, t_r};
    case (s_r)
      SMP_XP: cur_x = cur_x + HALF;
      SMP_XM: cur_x = cur_x - HALF;
      SMP_YP: cur_y = cur_y + HALF;
      SMP_YM: cur_y = cur_y - HALF;
      SMP_TP: cur_t = cur_t + HALF;
      SMP_TM: cur_t = cur_t - HALF;
      default: ;
    endcase
    top_x = top_of(sx_r, MAX_SAMPLES_X);
    top_y = top_of(sy_r, MAX_SAMPLES_Y);
    top_t = top_of({4'd0, nf_r}, MAX_FRAMES);
    cx = cell_of(cur_x, top_x);
    cy = cell_of(cur_y, top_y);
    ct = cell_of(cur_t, top_t);
  end

  // ---------------------------------------------------------------------------
  // shared blend unit
  blend_req_t              bl_req;
  logic                    bl_done;
  logic signed [VAL_W-1:0] bl_res;
  logic                    in_blend;

  assign in_blend = (state_r == S_BLT) || (state_r == S_BLY) || (state_r == S_BLX);

  always_comb begin
    bl_req.start = in_blend && !bl_wait_r;
    bl_req.a     = cu_r[0];
    bl_req.b     = cu_r[1];
    bl_req.w     = wy_r;
    unique case (state_r)
      S_BLT: begin
        bl_req.w = wt_r;
        if (bi_r[0]) begin
          bl_req.a = cv_r[k_r];
          bl_req.b = rd_v;
        end else begin
          bl_req.a = cu_r[k_r];
          bl_req.b = rd_u;
        end
      end
      S_BLY: begin
        case (bi_r)
          2'd0: begin bl_req.a = cu_r[0]; bl_req.b = cu_r[1]; end
          2'd1: begin bl_req.a = cu_r[2]; bl_req.b = cu_r[3]; end
          2'd2: begin bl_req.a = cv_r[0]; bl_req.b = cv_r[1]; end
          default: begin bl_req.a = cv_r[2]; bl_req.b = cv_r[3]; end
        endcase
      end
      S_BLX: begin
        bl_req.w = wx_r;
        if (bi_r[0]) begin
          bl_req.a = cv_r[0];
          bl_req.b = cv_r[2];
        end else begin
          bl_req.a = cu_r[0];
          bl_req.b = cu_r[2];
        end
      end
      default: ;
    endcase
  end

  vfts_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bl_req),
    .done  (bl_done),
    .res   (bl_res)
  );

  // ---------------------------------------------------------------------------
  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= SAMPLES_X_RST;
      sy_r <= SAMPLES_Y_RST;
      nf_r <= NUM_FRAMES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SAMPLES_X:  sx_r <= cfg_data;
        CFG_SAMPLES_Y:  sy_r <= cfg_data;
        CFG_NUM_FRAMES: nf_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  logic last_point;
  assign last_point = (cmd_r != CMD_DERIV) || (s_r == SMP_TM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bl_wait_r <= 1'b0;
      k_r       <= 2'd0;
      bi_r      <= 2'd0;
      s_r       <= SMP_CENTER;
    end else begin
      if (bl_req.start) begin
        bl_wait_r <= 1'b1;
      end else if (bl_done) begin
        bl_wait_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            s_r <= SMP_CENTER;
            if ((in_command == CMD_INTERP) || (in_command == CMD_DERIV)) begin
              state_r <= S_SETUP;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_SETUP: begin
          k_r     <= 2'd0;
          state_r <= S_RD0;
        end
        S_RD0: state_r <= S_CAP0;
        S_CAP0: begin
          if (wt_nz_r) begin
            state_r <= S_RD1;
          end else if (k_r == 2'd3) begin
            bi_r    <= 2'd0;
            state_r <= S_BLY;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_RD0;
          end
        end
        S_RD1: begin
          bi_r    <= 2'd0;
          state_r <= S_BLT;
        end
        S_BLT: begin
          if (bl_done) begin
            if (bi_r == 2'd0) begin
              bi_r <= 2'd1;
            end else if (k_r == 2'd3) begin
              bi_r    <= 2'd0;
              state_r <= S_BLY;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= S_RD0;
            end
          end
        end
        S_BLY: begin
          if (bl_done) begin
            bi_r <= bi_r + 2'd1;
            if (bi_r == 2'd3) begin
              state_r <= S_BLX;
            end
          end
        end
        S_BLX: begin
          if (bl_done) begin
            if (bi_r == 2'd0) begin
              bi_r <= 2'd1;
            end else if (last_point) begin
              state_r <= S_OUT;
            end else begin
              s_r     <= s_r + 3'd1;
              state_r <= S_SETUP;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_command;
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
      t_r   <= in_pos_t;
    end
    if (state_r == S_SETUP) begin
      px_r    <= cx[XW-1:0];
      py_r    <= cy[YW-1:0];
      pt_r    <= ct[FW-1:0];
      px1_r   <= (cx == top_x) ? cx[XW-1:0] : cx[XW-1:0] + XW'(1);
      py1_r   <= (cy == top_y) ? cy[YW-1:0] : cy[YW-1:0] + YW'(1);
      pt1_r   <= (ct == top_t) ? ct[FW-1:0] : ct[FW-1:0] + FW'(1);
      wx_r    <= wgt_of(cur_x, cx);
      wy_r    <= wgt_of(cur_y, cy);
      wt_r    <= wgt_of(cur_t, ct);
      wt_nz_r <= (wgt_of(cur_t, ct) != '0);
    end
    if (state_r == S_CAP0) begin
      cu_r[k_r] <= rd_u;
      cv_r[k_r] <= rd_v;
    end
    if (bl_done) begin
      unique case (state_r)
        S_BLT: begin
          if (bi_r[0]) cv_r[k_r] <= bl_res;
          else         cu_r[k_r] <= bl_res;
        end
        S_BLY: begin
          case (bi_r)
            2'd0: cu_r[0] <= bl_res;
            2'd1: cu_r[2] <= bl_res;
            2'd2: cv_r[0] <= bl_res;
            default: cv_r[2] <= bl_res;
          endcase
        end
        S_BLX: begin
          if (bi_r[0]) begin
            su_r[s_r] <= cu_r[0];
            sv_r[s_r] <= bl_res;
          end else begin
            cu_r[0] <= bl_res;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  logic signed [63:0] dux, duy, dvx, dvy;

  always_comb begin
    dux = 64'(su_r[SMP_XP]) - 64'(su_r[SMP_XM]);
    duy = 64'(su_r[SMP_YP]) - 64'(su_r[SMP_YM]);
    dvx = 64'(sv_r[SMP_XP]) - 64'(sv_r[SMP_XM]);
    dvy = 64'(sv_r[SMP_YP]) - 64'(sv_r[SMP_YM]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && (!out_valid_r || out_ready)) begin
      for (int i = 0; i < 9; i++) begin
        o_r[i] <= '0;
      end
      case (cmd_r)
        CMD_INTERP: begin
          o_r[0] <= su_r[SMP_CENTER];
          o_r[1] <= sv_r[SMP_CENTER];
        end
        CMD_DERIV: begin
          o_r[0] <= su_r[SMP_CENTER];
          o_r[1] <= sv_r[SMP_CENTER];
          o_r[2] <= sat32(dux);
          o_r[3] <= sat32(duy);
          o_r[4] <= sat32(64'(su_r[SMP_TP]) - 64'(su_r[SMP_TM]));
          o_r[5] <= sat32(dvx);
          o_r[6] <= sat32(dvy);
          o_r[7] <= sat32(64'(sv_r[SMP_TP]) - 64'(sv_r[SMP_TM]));
          o_r[8] <= sat32(dvx - duy);  // from unsaturated differences
        end
        default: ;
      endcase
    end
  end

  assign out_value_u   = o_r[0];
  assign out_value_v   = o_r[1];
  assign out_du_dx     = o_r[2];
  assign out_du_dy     = o_r[3];
  assign out_du_dt     = o_r[4];
  assign out_dv_dx     = o_r[5];
  assign out_dv_dy     = o_r[6];
  assign out_dv_dt     = o_r[7];
  assign out_vorticity = o_r[8];

  // ---------------------------------------------------------------------------
  // assertions
  `VFTS_ASSERT_IMP(a_done_in_blend, bl_done, in_blend, "blend result outside a blend step")
  `VFTS_ASSERT_IMP(a_rd1_needs_wt, state_r == S_RD1, wt_nz_r, "second frame read, zero weight")
  `VFTS_ASSERT_NXT(a_busy_after_acc, in_acc, !in_ready, "ready right after accepting an item")

endmodule

// ----- rtl/vfts_ram.sv -----
module vfts_ram import vfts_pkg::*; #(
  parameter int WIDTH = 64,
  parameter int DEPTH = MAX_FRAMES_DEF * MAX_SAMPLES_Y_DEF * MAX_SAMPLES_X_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/vfts_blend.sv -----
// a + floor(((b - a) * w + 128) / 256), saturated.
module vfts_blend import vfts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  blend_req_t              req,
  output logic                    done,
  output logic signed [VAL_W-1:0] res
);

  logic [2:0]               step_r;
  logic signed [VAL_W-1:0]  a_r;
  logic signed [VAL_W:0]    diff_r;
  logic signed [WGT_W-1:0]  w_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [VAL_W-1:0]  res_r;
  logic signed [ACC_W-1:0]  pp_lo;
  logic signed [ACC_W-1:0]  pp_hi;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [63:0]       sum;

  always_comb begin
    pp_lo = diff_r * $signed({1'b0, w_r[WLO_W-1:0]});
    pp_hi = diff_r * $signed(w_r[WGT_W-1:WLO_W]);
    rnd   = acc_r + ACC_W'(ROUND_HALF);
    sum   = {{(64-VAL_W){a_r[VAL_W-1]}}, a_r} + {{(64-ACC_W+8){rnd[ACC_W-1]}}, rnd[ACC_W-1:8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
    end else begin
      case (step_r)
        3'd0: if (req.start) step_r <= 3'd1;
        3'd4: step_r <= 3'd0;
        default: step_r <= step_r + 3'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (step_r)
      3'd0: begin
        if (req.start) begin
          a_r    <= req.a;
          w_r    <= req.w;
          diff_r <= {req.b[VAL_W-1], req.b} - {req.a[VAL_W-1], req.a};
        end
      end
      3'd1: acc_r <= pp_lo;
      3'd2: acc_r <= acc_r + (pp_hi <<< WLO_W);
      3'd3: res_r <= sat32(sum);
      default: ;
    endcase
  end

  assign done = (step_r == 3'd4);
  assign res  = res_r;

endmodule
